// ===== hw/rtl/qphs_pkg.sv =====
// Package for the quadratic probing hash set: field widths, codes, FSM states
// and the packed request and response words. No dependencies.
package qphs_pkg;

    localparam int KEY_W       = 31;
    localparam int CFG_W       = 11;
    localparam int SLOT_W      = 10;
    localparam int DEPTH_DEF   = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // The home slot is found by a restoring remainder, four key bits per cycle.
    localparam int DIV_BITS    = 4;
    localparam int DIV_CYC     = (KEY_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W       = DIV_CYC * DIV_BITS;
    localparam int DIV_CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        STS_INSERTED  = 2'd0,
        STS_FOUND     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_req              req_type;
        logic [KEY_W-1:0]  key_value;
        logic              batch_last;
    } t_req_word;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic              batch_done;
    } t_rsp_word;

endpackage

// ===== hw/rtl/quadratic_probe_hash_set.sv =====
// Top level of the quadratic probing hash set: slot memory, remainder unit,
// probe sequencer and output register. Depends on qphs_pkg.
//
// The block takes one request word at a time on the input channel (valid and
// ready) and returns exactly one response word on the output channel. An
// insert stores the key in the first empty slot on its probe path; a search
// stops at a matching key, an empty slot, or after table_size probes.
// The configuration channel writes table_size; it is always ready and should
// only be written while no request is in flight.
// Steps: the word is taken in ST_IDLE, key mod size is formed in ST_DIV,
// ST_PROBE issues the probes and checks each slot as its memory read
// returns, and ST_FIN moves the result into the output register.
// The next word is taken only after the result has reached that register.
// The slot memory has one read and one write port with a registered read;
// reads are issued every cycle while the previous slot is checked.
// After reset the block clears the slot memory, one entry per cycle, over
// all TABLE_DEPTH entries; input ready stays low during that pass.
// A stalled receiver holds the result in the output register; the block may
// still take and process the next word, which then waits for that register.
module quadratic_probe_hash_set #(
    parameter int TABLE_DEPTH = qphs_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  qphs_pkg::t_req_word          i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output qphs_pkg::t_rsp_word          o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [qphs_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (SW > qphs_pkg::CFG_W) ? SW : qphs_pkg::CFG_W;
    localparam int KW = qphs_pkg::KEY_W;

    logic [KW:0] mem [TABLE_DEPTH];

    qphs_pkg::t_state    r_state, n_state;
    logic [qphs_pkg::CFG_W-1:0] r_cfg;
    logic [qphs_pkg::DIV_W-1:0] r_kbits, n_kbits;
    logic [qphs_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [SW-1:0]       r_rem, n_rem;
    qphs_pkg::t_req_word r_req, n_req;
    logic [SW-1:0]       r_pos, n_pos;
    logic [SW-1:0]       r_d, n_d;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_chk_pos, n_chk_pos;
    logic                r_rd_vld, n_rd_vld;
    qphs_pkg::t_rsp_word r_res, n_res;
    logic                r_out_vld, n_out_vld;
    qphs_pkg::t_rsp_word r_out, n_out;
    logic [AW-1:0]       r_clr, n_clr;
    logic [KW:0]         r_rd_data;

    logic [CW-1:0] cfg_ext;
    logic [SW-1:0] eff_size;
    logic          in_acc;
    logic          is_ins;
    logic          rd_used;
    logic          key_match;
    logic          hit;
    logic          more;
    logic          probe_end;
    logic          div_last;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [KW:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [SW:0]   rem_w;
    logic [SW-1:0] rem_v;
    logic [qphs_pkg::DIV_W-1:0] kb_v;
    logic [SW:0]   pos_sum;
    logic [SW:0]   d_sum;

    always_comb begin
        cfg_ext = CW'(r_cfg);
        if (r_cfg == '0) begin
            eff_size = SW'(1);
        end else if (cfg_ext > CW'(TABLE_DEPTH)) begin
            eff_size = SW'(TABLE_DEPTH);
        end else begin
            eff_size = SW'(cfg_ext);
        end
    end

    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        is_ins    = (r_req.req_type == qphs_pkg::REQ_INSERT);
        rd_used   = r_rd_data[KW];
        key_match = (r_rd_data[KW-1:0] == r_req.key_value);
        hit       = r_rd_vld && (!rd_used || (!is_ins && key_match));
        more      = (r_cnt < eff_size);
        probe_end = hit || (!r_rd_vld && !more);
        div_last  = (r_div_cnt == qphs_pkg::DIV_CNT_W'(qphs_pkg::DIV_CYC - 1));
        out_free  = !r_out_vld || i_out_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qphs_pkg::ST_CLEAR: begin
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = qphs_pkg::ST_IDLE;
                end
            end
            qphs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = qphs_pkg::ST_DIV;
                end
            end
            qphs_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = qphs_pkg::ST_PROBE;
                end
            end
            qphs_pkg::ST_PROBE: begin
                if (probe_end) begin
                    n_state = qphs_pkg::ST_FIN;
                end
            end
            qphs_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = qphs_pkg::ST_IDLE;
                end
            end
            default: n_state = qphs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_kbits   = r_kbits;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_req     = r_req;
        n_pos     = r_pos;
        n_d       = r_d;
        n_cnt     = r_cnt;
        n_chk_pos = r_chk_pos;
        n_rd_vld  = r_rd_vld;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = r_chk_pos[AW-1:0];
        mem_wdata = {1'b1, r_req.key_value};
        mem_raddr = r_pos[AW-1:0];
        rem_v     = r_rem;
        kb_v      = r_kbits;
        rem_w     = '0;
        pos_sum   = {1'b0, r_pos} + {1'b0, r_d};
        d_sum     = {1'b0, r_d} + (SW+1)'(2);

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            qphs_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            qphs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_req     = i_in_word;
                    n_kbits   = qphs_pkg::DIV_W'(i_in_word.key_value);
                    n_rem     = '0;
                    n_div_cnt = '0;
                end
            end
            qphs_pkg::ST_DIV: begin
                for (int i = 0; i < qphs_pkg::DIV_BITS; i++) begin
                    rem_w = {rem_v, kb_v[qphs_pkg::DIV_W-1]};
                    kb_v  = kb_v << 1;
                    if (rem_w >= {1'b0, eff_size}) begin
                        rem_w = rem_w - {1'b0, eff_size};
                    end
                    rem_v = rem_w[SW-1:0];
                end
                n_rem     = rem_v;
                n_kbits   = kb_v;
                n_div_cnt = r_div_cnt + qphs_pkg::DIV_CNT_W'(1);
                if (div_last) begin
                    n_pos    = rem_v;
                    n_d      = (eff_size == SW'(1)) ? '0 : SW'(1);
                    n_cnt    = '0;
                    n_rd_vld = 1'b0;
                end
            end
            qphs_pkg::ST_PROBE: begin
                n_rd_vld = 1'b0;
                n_res.batch_done = r_req.batch_last;
                if (hit) begin
                    if (is_ins) begin
                        mem_we           = 1'b1;
                        n_res.status     = qphs_pkg::STS_INSERTED;
                        n_res.slot_index = qphs_pkg::SLOT_W'(r_chk_pos);
                    end else if (rd_used) begin
                        n_res.status     = qphs_pkg::STS_FOUND;
                        n_res.slot_index = qphs_pkg::SLOT_W'(r_chk_pos);
                    end else begin
                        n_res.status     = qphs_pkg::STS_NOT_FOUND;
                        n_res.slot_index = '0;
                    end
                end else if (more) begin
                    n_chk_pos = r_pos;
                    n_rd_vld  = 1'b1;
                    n_cnt     = r_cnt + SW'(1);
                    if (pos_sum >= {1'b0, eff_size}) begin
                        pos_sum = pos_sum - {1'b0, eff_size};
                    end
                    if (d_sum >= {1'b0, eff_size}) begin
                        d_sum = d_sum - {1'b0, eff_size};
                    end
                    n_pos = pos_sum[SW-1:0];
                    n_d   = d_sum[SW-1:0];
                end else if (!r_rd_vld) begin
                    n_res.status     = is_ins ? qphs_pkg::STS_FULL
                                              : qphs_pkg::STS_NOT_FOUND;
                    n_res.slot_index = '0;
                end
            end
            qphs_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qphs_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_cfg     <= qphs_pkg::CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= n_rd_vld;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kbits   <= n_kbits;
        r_div_cnt <= n_div_cnt;
        r_rem     <= n_rem;
        r_req     <= n_req;
        r_pos     <= n_pos;
        r_d       <= n_d;
        r_cnt     <= n_cnt;
        r_chk_pos <= n_chk_pos;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == qphs_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ===== hw/rtl/qphs_checker.sv =====
// Port-level checker for the quadratic probing hash set, bound to the top
// level. Depends on qphs_pkg and quadratic_probe_hash_set.
module qphs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input qphs_pkg::t_req_word        i_in_word,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input qphs_pkg::t_rsp_word        o_out_word,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [qphs_pkg::CFG_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output word dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("Output word changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A second word was taken while one is being processed.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("Block not quiet right after reset.");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == qphs_pkg::STS_NOT_FOUND ||
                        o_out_word.status == qphs_pkg::STS_FULL)
        |-> o_out_word.slot_index == '0)
        else $error("Miss or full result carries a nonzero slot.");

endmodule

bind quadratic_probe_hash_set qphs_checker u_qphs_checker (.*);

// ===== test/tb_quadratic_probe_hash_set.sv =====
// Testbench for quadratic_probe_hash_set: directed and random insert and search words
// under several table sizes and handshake idle patterns, checked against a local model.
// Depends on qphs_pkg and the quadratic_probe_hash_set RTL.
module tb_quadratic_probe_hash_set;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = qphs_pkg::DEPTH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 40;
    localparam int LIMIT_CYCLES  = 3000000;

    class hash_set_scoreboard;
        logic [qphs_pkg::CFG_W-1:0] size_reg;
        bit                         used [DEPTH];
        logic [qphs_pkg::KEY_W-1:0] keys [DEPTH];
        qphs_pkg::t_rsp_word        expected_q [$];
        int                         errors;
        int                         accepted;
        int                         checked;
        int                         status_seen [4];

        function new();
            size_reg = qphs_pkg::CFG_RESET;
            errors   = 0;
            accepted = 0;
            checked  = 0;
            foreach (used[i]) used[i] = 1'b0;
            foreach (keys[i]) keys[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_size(logic [qphs_pkg::CFG_W-1:0] v);
            size_reg = v;
        endfunction

        function int unsigned active_slots();
            if (size_reg == 0) return 1;
            if (size_reg > DEPTH) return DEPTH;
            return size_reg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Walks the quadratic probe path and updates the local copy of the table.
        function void note_request(qphs_pkg::t_req_word w);
            int unsigned         s;
            int unsigned         home;
            int unsigned         idx;
            bit                  stop;
            qphs_pkg::t_rsp_word r;
            s    = active_slots();
            home = {1'b0, w.key_value} % s;
            if (w.req_type == qphs_pkg::REQ_INSERT) r.status = qphs_pkg::STS_FULL;
            else r.status = qphs_pkg::STS_NOT_FOUND;
            r.slot_index = '0;
            r.batch_done = w.batch_last;
            stop = 1'b0;
            for (int unsigned j = 0; j < s && !stop; j++) begin
                idx = (home + (j * j) % s) % s;
                if (w.req_type == qphs_pkg::REQ_INSERT) begin
                    if (!used[idx]) begin
                        used[idx]    = 1'b1;
                        keys[idx]    = w.key_value;
                        r.status     = qphs_pkg::STS_INSERTED;
                        r.slot_index = qphs_pkg::SLOT_W'(idx);
                        stop         = 1'b1;
                    end
                end else if (!used[idx]) begin
                    stop = 1'b1;
                end else if (keys[idx] == w.key_value) begin
                    r.status     = qphs_pkg::STS_FOUND;
                    r.slot_index = qphs_pkg::SLOT_W'(idx);
                    stop         = 1'b1;
                end
            end
            accepted++;
            status_seen[r.status]++;
            expected_q.push_back(r);
        endfunction

        task check_result(input qphs_pkg::t_rsp_word got);
            qphs_pkg::t_rsp_word want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word %h arrived with nothing expected", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 checked, got.status, want.status));
            if (got.slot_index !== want.slot_index)
                report($sformatf("result %0d slot_index %0d, expected %0d",
                                 checked, got.slot_index, want.slot_index));
            if (got.batch_done !== want.batch_done)
                report($sformatf("result %0d batch_done %0b, expected %0b",
                                 checked, got.batch_done, want.batch_done));
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    qphs_pkg::t_req_word        i_in_word;
    logic                       o_out_valid;
    logic                       i_out_ready;
    qphs_pkg::t_rsp_word        o_out_word;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [qphs_pkg::CFG_W-1:0] i_cfg_data;

    hash_set_scoreboard         sb = new();
    logic [qphs_pkg::KEY_W-1:0] key_pool [$];
    int                         tx_idle_pct = 0;
    int                         rx_stall_pct = 0;
    int                         cycle_count = 0;

    quadratic_probe_hash_set #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, sb.pending());
        $display("tb_quadratic_probe_hash_set failed");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_word);
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic qphs_pkg::t_req_word make_req(qphs_pkg::t_req op,
                                                     logic [qphs_pkg::KEY_W-1:0] key,
                                                     logic last);
        qphs_pkg::t_req_word w;
        w.req_type   = op;
        w.key_value  = key;
        w.batch_last = last;
        return w;
    endfunction

    // Valid stays high from one word to the next unless an idle gap is drawn.
    task automatic send_req(input qphs_pkg::t_req_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(w);
        if (w.req_type == qphs_pkg::REQ_INSERT) key_pool.push_back(w.key_value);
    endtask

    task automatic write_size(input logic [qphs_pkg::CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_size(v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        qphs_pkg::t_req_word w;
        int unsigned         s;
        int unsigned         pick;
        repeat (count) begin
            s = sb.active_slots();
            w.req_type = qphs_pkg::t_req'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 40 && key_pool.size() > 0)
                w.key_value = key_pool[$urandom_range(key_pool.size() - 1)];
            else if (pick < 70)
                w.key_value = qphs_pkg::KEY_W'($urandom_range(s - 1)
                                               + s * $urandom_range(2000));
            else if (pick < 88)
                w.key_value = qphs_pkg::KEY_W'($urandom());
            else if (pick < 94)
                w.key_value = qphs_pkg::KEY_W'($urandom_range(15));
            else
                w.key_value = qphs_pkg::KEY_W'(32'h7FFF_FFFF - $urandom_range(15));
            w.batch_last = 1'($urandom_range(1));
            send_req(w);
        end
        i_in_valid <= 1'b0;
    endtask

    logic [qphs_pkg::CFG_W-1:0] phase_sizes [15] = '{
        11'd1, 11'd0, 11'd2, 11'd3, 11'd5, 11'd8, 11'd13, 11'd16,
        11'd31, 11'd64, 11'd2047, 11'd1000, 11'd7, 11'd1024, 11'd512
    };
    int idle_modes [4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{17, 17}};

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size of 1024: empty table, extreme keys, collisions and duplicates.
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'd0, 1'b0));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'd0, 1'b0));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'h7FFF_FFFF, 1'b1));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'h7FFF_FFFF, 1'b1));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'd0, 1'b0));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'd1024, 1'b0));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'd2048, 1'b0));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'd0, 1'b1));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'd2048, 1'b0));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'd3072, 1'b1));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'd2047, 1'b0));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'd2047, 1'b1));
        send_req(make_req(qphs_pkg::REQ_INSERT, 31'h2AAA_AAAA, 1'b1));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'h5555_5555, 1'b0));
        send_req(make_req(qphs_pkg::REQ_SEARCH, 31'h2AAA_AAAA, 1'b0));
        i_in_valid <= 1'b0;
        wait_drained();

        foreach (phase_sizes[p]) begin
            write_size(phase_sizes[p]);
            tx_idle_pct  = idle_modes[p % 4][0];
            rx_stall_pct = idle_modes[p % 4][1];
            send_random(PHASE_WORDS);
            wait_drained();
        end

        $display("Sent %0d request words and checked %0d results over %0d table sizes.",
                 sb.accepted, sb.checked, $size(phase_sizes) + 1);
        $display("Expected outcomes: %0d inserted, %0d found, %0d not found, %0d full.",
                 sb.status_seen[qphs_pkg::STS_INSERTED],
                 sb.status_seen[qphs_pkg::STS_FOUND],
                 sb.status_seen[qphs_pkg::STS_NOT_FOUND],
                 sb.status_seen[qphs_pkg::STS_FULL]);
        if (sb.errors == 0) begin
            $display("tb_quadratic_probe_hash_set passed");
        end else begin
            $display("tb_quadratic_probe_hash_set failed");
        end
        $finish;
    end
endmodule
